[hw/rtl/lsx_pkg.sv]
// Shared constants, types and helpers for the Laplacian stencil block.
`timescale 1ns / 1ps
`default_nettype none

package lsx_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_COLS      = 1024;
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int CFG_COL_BITS  = 11;
    localparam int ROW_BITS      = 16;
    localparam int SLOTS         = 5;
    localparam int SLOT_BITS     = 3;
    localparam int OUT_BITS      = 21;
    localparam int VERT_BITS     = SAMPLE_BITS + 4;
    localparam int CALC_BITS     = SAMPLE_BITS + 5;
    localparam int QDEPTH        = 4;
    localparam int QPTR_BITS     = $clog2(QDEPTH);
    localparam int QCNT_BITS     = QPTR_BITS + 1;
    localparam int PADDR_BITS    = 3;
    localparam int PDATA_BITS    = 32;
    localparam int MIN_DIM       = 4;

    localparam logic [CFG_COL_BITS-1:0] RESET_COLS = CFG_COL_BITS'(1024);
    localparam logic [ROW_BITS-1:0]     RESET_ROWS = ROW_BITS'(1024);
    localparam logic [ROW_BITS-1:0]     FIRST_OUT_ROW = ROW_BITS'(3);
    localparam logic [ROW_BITS-1:0]     PRELOAD_ROW   = ROW_BITS'(2);

    localparam logic signed [CALC_BITS-1:0] W_EDGE = CALC_BITS'(2);
    localparam logic signed [CALC_BITS-1:0] W_NEAR = CALC_BITS'(5);
    localparam logic signed [CALC_BITS-1:0] W_MID  = CALC_BITS'(4);

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [SLOT_BITS-1:0]          slot_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [COL_BITS-1:0] c_last;
        logic [ROW_BITS-1:0] r_last;
    } frame_cfg_t;

    typedef struct packed {
        logic                        emit;
        logic                        frame_end;
        logic                        left;
        logic                        right;
        logic signed [CALC_BITS-1:0] vert;
        sample_t                     ahead;
    } q_item_t;

    function automatic slot_t slot_add(input slot_t s, input slot_t k);
        logic [SLOT_BITS:0] sum;
        sum = {1'b0, s} + {1'b0, k};
        if (sum >= (SLOT_BITS + 1)'(SLOTS))
        begin
            sum = sum - (SLOT_BITS + 1)'(SLOTS);
        end
        return sum[SLOT_BITS-1:0];
    endfunction

    function automatic logic signed [CALC_BITS-1:0] ext(input sample_t v);
        return CALC_BITS'(v);
    endfunction

    // 2*m0 - 5*m1 + 4*m2 - m3
    function automatic logic signed [CALC_BITS-1:0] edge_term(
        input sample_t m0,
        input sample_t m1,
        input sample_t m2,
        input sample_t m3
    );
        return W_EDGE * ext(m0) - W_NEAR * ext(m1) + W_MID * ext(m2) - ext(m3);
    endfunction

    function automatic logic signed [CALC_BITS-1:0] mid_term(
        input sample_t a,
        input sample_t m,
        input sample_t b
    );
        return ext(a) + ext(b) - W_EDGE * ext(m);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/laplacian_stencil_extrapolated.sv]
// Top level: configuration registers and the front, queue and back parts.
`timescale 1ns / 1ps
`default_nettype none

// Streams a raster frame of signed samples and returns four times the discrete
// Laplacian of each sample, in raster order, with one-sided cubic extrapolation
// on edges and corners. One item is accepted per clock when the result side keeps
// up; each push fetches its stencil from a five-row line store whose banks give
// one vertical read and one lookahead read per cycle. Results trail input by three
// rows; after the frame's last sample, drain items (or further pushes) flush the
// remaining rows one result each. Writing frame_cols or frame_rows restarts the
// frame; write them only while the block is idle.
module laplacian_stencil_extrapolated (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lsx_pkg::PADDR_BITS-1:0]       paddr,
    input  wire logic [lsx_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [lsx_pkg::PDATA_BITS-1:0]            prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 cmd,
    input  wire logic signed [lsx_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [lsx_pkg::OUT_BITS-1:0]       laplace_quarters,
    output logic                                      frame_end
);

    logic [lsx_pkg::CFG_COL_BITS-1:0] cols_reg;
    logic [lsx_pkg::ROW_BITS-1:0]     rows_reg;
    logic                             cfg_write;
    logic                             reg_index;
    lsx_pkg::frame_cfg_t              cfg;
    int unsigned                      cols_eff;

    logic                             q_push;
    lsx_pkg::q_item_t                 q_item;
    logic                             q_pop;
    logic                             head_valid;
    lsx_pkg::q_item_t                 head_item;
    logic [lsx_pkg::QCNT_BITS-1:0]    q_count;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= lsx_pkg::RESET_COLS;
            rows_reg <= lsx_pkg::RESET_ROWS;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                lsx_pkg::REG_COLS: cols_reg <= pwdata[lsx_pkg::CFG_COL_BITS-1:0];
                lsx_pkg::REG_ROWS: rows_reg <= pwdata[lsx_pkg::ROW_BITS-1:0];
                default:           cols_reg <= cols_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            lsx_pkg::REG_COLS: prdata = lsx_pkg::PDATA_BITS'(cols_reg);
            lsx_pkg::REG_ROWS: prdata = lsx_pkg::PDATA_BITS'(rows_reg);
            default:           prdata = '0;
        endcase

        cols_eff = 32'(cols_reg);
        if (cols_eff < lsx_pkg::MIN_DIM)
        begin
            cols_eff = lsx_pkg::MIN_DIM;
        end
        if (cols_eff > lsx_pkg::MAX_COLS)
        begin
            cols_eff = lsx_pkg::MAX_COLS;
        end
        cfg.c_last = lsx_pkg::COL_BITS'(cols_eff - 1);
        if (rows_reg < lsx_pkg::ROW_BITS'(lsx_pkg::MIN_DIM))
        begin
            cfg.r_last = lsx_pkg::ROW_BITS'(lsx_pkg::MIN_DIM - 1);
        end
        else
        begin
            cfg.r_last = rows_reg - lsx_pkg::ROW_BITS'(1);
        end
    end

    lsx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .restart  (cfg_write),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sample   (sample),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    lsx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    lsx_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_item        (head_item),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .laplace_quarters (laplace_quarters),
        .frame_end        (frame_end)
    );

endmodule

`default_nettype wire

[hw/rtl/lsx_front.sv]
// Front part: position tracking, line store, vertical term and lookahead fetch.
`timescale 1ns / 1ps
`default_nettype none

module lsx_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lsx_pkg::frame_cfg_t                  cfg,
    input  wire logic                                 restart,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 cmd,
    input  wire lsx_pkg::sample_t                     sample,
    input  wire logic [lsx_pkg::QCNT_BITS-1:0]        q_count,
    output logic                                      q_push,
    output lsx_pkg::q_item_t                          q_item
);

    logic [lsx_pkg::COL_BITS-1:0] in_col_reg, in_col_next;
    logic [lsx_pkg::ROW_BITS-1:0] in_row_reg, in_row_next;
    lsx_pkg::slot_t               in_slot_reg, in_slot_next;
    logic [lsx_pkg::COL_BITS-1:0] out_col_reg, out_col_next;
    logic [lsx_pkg::ROW_BITS-1:0] out_row_reg, out_row_next;
    lsx_pkg::slot_t               out_slot_reg, out_slot_next;
    logic [lsx_pkg::COL_BITS-1:0] la_col_reg, la_col_next;
    logic [lsx_pkg::ROW_BITS-1:0] la_row_reg, la_row_next;
    lsx_pkg::slot_t               la_slot_reg, la_slot_next;

    logic f1_valid_reg;
    logic f1_emit_reg;
    logic f1_top_reg;
    logic f1_bottom_reg;
    logic f1_left_reg;
    logic f1_right_reg;
    logic f1_end_reg;
    lsx_pkg::slot_t  f1_slot_reg;
    lsx_pkg::slot_t  f1_la_slot_reg;
    lsx_pkg::sample_t f1_sample_reg;

    lsx_pkg::sample_t rda_reg [lsx_pkg::SLOTS];
    lsx_pkg::sample_t rdb_reg [lsx_pkg::SLOTS];

    logic accept;
    logic done;
    logic wr_en;
    logic emit;
    logic preload;
    logic issue;
    logic out_last;

    assign in_ready = (q_count + lsx_pkg::QCNT_BITS'(f1_valid_reg))
                      < lsx_pkg::QCNT_BITS'(lsx_pkg::QDEPTH);
    assign accept   = in_valid & in_ready;
    assign done     = in_row_reg > cfg.r_last;
    assign wr_en    = accept & (cmd == lsx_pkg::CMD_PUSH) & ~done;
    assign emit     = accept & (done | (wr_en & (in_row_reg >= lsx_pkg::FIRST_OUT_ROW)));
    assign preload  = wr_en & (in_row_reg == lsx_pkg::PRELOAD_ROW)
                      & (in_col_reg >= (cfg.c_last - lsx_pkg::COL_BITS'(2)));
    assign issue    = emit | preload;
    assign out_last = (out_row_reg == cfg.r_last) & (out_col_reg == cfg.c_last);

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        la_col_next   = la_col_reg;
        la_row_next   = la_row_reg;
        la_slot_next  = la_slot_reg;

        if (wr_en)
        begin
            if (in_col_reg == cfg.c_last)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + lsx_pkg::ROW_BITS'(1);
                in_slot_next = lsx_pkg::slot_add(in_slot_reg, lsx_pkg::slot_t'(1));
            end
            else
            begin
                in_col_next = in_col_reg + lsx_pkg::COL_BITS'(1);
            end
        end

        if (issue)
        begin
            if (la_col_reg == cfg.c_last)
            begin
                la_col_next  = '0;
                la_row_next  = la_row_reg + lsx_pkg::ROW_BITS'(1);
                la_slot_next = lsx_pkg::slot_add(la_slot_reg, lsx_pkg::slot_t'(1));
            end
            else
            begin
                la_col_next = la_col_reg + lsx_pkg::COL_BITS'(1);
            end
        end

        if (emit)
        begin
            if (out_col_reg == cfg.c_last)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + lsx_pkg::ROW_BITS'(1);
                out_slot_next = lsx_pkg::slot_add(out_slot_reg, lsx_pkg::slot_t'(1));
            end
            else
            begin
                out_col_next = out_col_reg + lsx_pkg::COL_BITS'(1);
            end
        end

        if (restart || (emit && out_last))
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            la_col_next   = '0;
            la_row_next   = '0;
            la_slot_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            la_col_reg   <= '0;
            la_row_reg   <= '0;
            la_slot_reg  <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            la_col_reg   <= la_col_next;
            la_row_reg   <= la_row_next;
            la_slot_reg  <= la_slot_next;
            f1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            f1_emit_reg    <= emit;
            f1_top_reg     <= out_row_reg == '0;
            f1_bottom_reg  <= out_row_reg == cfg.r_last;
            f1_left_reg    <= out_col_reg == '0;
            f1_right_reg   <= out_col_reg == cfg.c_last;
            f1_end_reg     <= out_last;
            f1_slot_reg    <= out_slot_reg;
            f1_la_slot_reg <= la_slot_reg;
            f1_sample_reg  <= sample;
        end
    end

    // one bank per row slot: write port, vertical read, lookahead read
    for (genvar b = 0; b < lsx_pkg::SLOTS; b++)
    begin : g_bank
        lsx_pkg::sample_t bank_mem [lsx_pkg::MAX_COLS];

        always_ff @(posedge clk)
        begin
            if (wr_en && (in_slot_reg == lsx_pkg::slot_t'(b)))
            begin
                bank_mem[in_col_reg] <= sample;
            end
        end

        always_ff @(posedge clk)
        begin
            rda_reg[b] <= bank_mem[out_col_reg];
            rdb_reg[b] <= bank_mem[la_col_reg];
        end
    end

    lsx_pkg::sample_t m_val;
    lsx_pkg::sample_t up1;
    lsx_pkg::sample_t up2;
    lsx_pkg::sample_t up3;
    lsx_pkg::sample_t dn1;
    lsx_pkg::sample_t dn2;

    always_comb
    begin
        m_val = rda_reg[f1_slot_reg];
        dn1   = rda_reg[lsx_pkg::slot_add(f1_slot_reg, lsx_pkg::slot_t'(1))];
        dn2   = rda_reg[lsx_pkg::slot_add(f1_slot_reg, lsx_pkg::slot_t'(2))];
        up3   = dn2;
        up2   = rda_reg[lsx_pkg::slot_add(f1_slot_reg, lsx_pkg::slot_t'(3))];
        up1   = rda_reg[lsx_pkg::slot_add(f1_slot_reg, lsx_pkg::slot_t'(4))];

        q_item.emit      = f1_emit_reg;
        q_item.frame_end = f1_end_reg;
        q_item.left      = f1_left_reg;
        q_item.right     = f1_right_reg;
        q_item.ahead     = rdb_reg[f1_la_slot_reg];
        if (f1_top_reg)
        begin
            // row three is the sample just pushed
            q_item.vert = lsx_pkg::edge_term(m_val, dn1, dn2, f1_sample_reg);
        end
        else if (f1_bottom_reg)
        begin
            q_item.vert = lsx_pkg::edge_term(m_val, up1, up2, up3);
        end
        else
        begin
            q_item.vert = lsx_pkg::mid_term(up1, m_val, dn1);
        end
    end

    assign q_push = f1_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/lsx_queue.sv]
// Short item queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module lsx_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire lsx_pkg::q_item_t              push_item,
    input  wire logic                          pop,
    output logic                               head_valid,
    output lsx_pkg::q_item_t                   head_item,
    output logic [lsx_pkg::QCNT_BITS-1:0]      count
);

    lsx_pkg::q_item_t                 entry_reg [lsx_pkg::QDEPTH];
    logic [lsx_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lsx_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lsx_pkg::QCNT_BITS-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lsx_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + lsx_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + lsx_pkg::QCNT_BITS'(push) - lsx_pkg::QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_item  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != lsx_pkg::QCNT_BITS'(lsx_pkg::QDEPTH)) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push == pop) |=> $stable(count_reg))
        else $error("queue count moved without net traffic");

endmodule

`default_nettype wire

[hw/rtl/lsx_back.sv]
// Back part: horizontal window, sum of both axes and output register.
`timescale 1ns / 1ps
`default_nettype none

module lsx_back (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   head_valid,
    input  wire lsx_pkg::q_item_t                       head_item,
    output logic                                        pop,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [lsx_pkg::OUT_BITS-1:0]         laplace_quarters,
    output logic                                        frame_end
);

    // win_reg[0] is the newest sample; after a shift the center is the result's own
    lsx_pkg::sample_t win_reg [6];

    logic                                 out_valid_reg, out_valid_next;
    logic signed [lsx_pkg::OUT_BITS-1:0]  result_reg;
    logic                                 end_reg;
    logic                                 load;
    logic signed [lsx_pkg::CALC_BITS-1:0] horiz;
    logic signed [lsx_pkg::CALC_BITS-1:0] total;

    assign pop  = head_valid & (~head_item.emit | ~out_valid_reg | out_ready);
    assign load = pop & head_item.emit;

    always_comb
    begin
        if (head_item.left)
        begin
            horiz = lsx_pkg::edge_term(win_reg[2], win_reg[1], win_reg[0], head_item.ahead);
        end
        else if (head_item.right)
        begin
            horiz = lsx_pkg::edge_term(win_reg[2], win_reg[3], win_reg[4], win_reg[5]);
        end
        else
        begin
            horiz = lsx_pkg::mid_term(win_reg[1], win_reg[2], win_reg[3]);
        end
        total          = head_item.vert + horiz;
        out_valid_next = load | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            win_reg[0] <= head_item.ahead;
            for (int i = 1; i < 6; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
        if (load)
        begin
            result_reg <= lsx_pkg::OUT_BITS'(total);
            end_reg    <= head_item.frame_end;
        end
    end

    assign out_valid        = out_valid_reg;
    assign laplace_quarters = result_reg;
    assign frame_end        = end_reg;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load)
        else $error("result overwritten while stalled");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop without item");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not shown");

endmodule

`default_nettype wire
